@@ rtl/core/sorted_key_child_page_macros.svh @@
// Assertion macros shared by the sorted key child page RTL
`ifndef SORTED_KEY_CHILD_PAGE_MACROS_SVH
`define SORTED_KEY_CHILD_PAGE_MACROS_SVH
`ifndef SYNTHESIS
// check a property on the rising clock, masked while reset is low
`define SKCP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("skcp assertion failed");
// check a property on the rising clock, also during reset
`define SKCP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("skcp assertion failed");
`else
`define SKCP_ASSERT(label, clk, rst_n, prop)
`define SKCP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/core/skcp_pkg.sv @@
// Types, codes and defaults for the sorted key child page
package skcp_pkg;

  localparam int unsigned MaxEntriesDefault = 256;

  typedef enum logic [2:0] {
    OP_LOOKUP  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_NEWROOT = 3'd3,
    OP_FIND    = 3'd4
  } skcp_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EXISTS   = 2'd2,
    ST_FULL     = 2'd3
  } skcp_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_CMP,
    S_LK_RD,
    S_SHIFT,
    S_SHIFT_WR,
    S_SCAN,
    S_SCAN_CMP,
    S_ROOT1,
    S_ROOT2,
    S_DONE
  } skcp_state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [63:0] key;
    logic [31:0]        child;
    logic [31:0]        left_id;
  } skcp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_child;
    logic [7:0]  found_index;
    logic [8:0]  entry_count;
  } skcp_out_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic child_eq;
  } skcp_cmp_t;

endpackage

@@ rtl/core/skcp_stream_if.sv @@
// Valid/ready channel carrying one word of a given payload type
interface skcp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/skcp_ram.sv @@
// Generic single write, single read RAM with registered read data
module skcp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/skcp_cmp.sv @@
// Shared compare unit: signed key order and child id match
module skcp_cmp
  import skcp_pkg::*;
(
  input  logic [63:0] mem_key_i,
  input  logic [63:0] probe_key_i,
  input  logic [31:0] mem_child_i,
  input  logic [31:0] probe_child_i,
  output skcp_cmp_t   res_o
);
  // compare stored entry against the probe
  always_comb begin
    res_o.gt       = $signed(mem_key_i) > $signed(probe_key_i);
    res_o.eq       = mem_key_i == probe_key_i;
    res_o.child_eq = mem_child_i == probe_child_i;
  end
endmodule

@@ rtl/core/sorted_key_child_page.sv @@
// Top level of the sorted key child page: sequencer, entry RAMs and compare unit
//
//   channel | dir | payload
//   in_i    | in  | operation, key, child, left_id
//   out_o   | out | status, found_child, found_index, entry_count
//
// One word at a time. Lookup: a binary search, each step a RAM read then a compare,
// then a read of the child. Insert/remove: search, then a shift of each entry
// after the position through the single RAM port pair, read then write.
// Find child: a linear scan, each slot read then compared. New root: left child in slot 0, key and child in slot 1.
// Reset clears the count and control only; entry RAMs need no clearing.
// A finished result waits in the output register; the next word is taken meanwhile.
`include "sorted_key_child_page_macros.svh"
module sorted_key_child_page
  import skcp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skcp_stream_if.sink   in_i,
  skcp_stream_if.source out_o
);
  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  skcp_state_e    state_q, state_d;
  skcp_in_t       req_q, req_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  lo_q, lo_d, hi_q, hi_d, pos_q, pos_d, idx_q, idx_d, mid_q, mid_d;
  logic           found_q, found_d;
  logic [1:0]     status_q, status_d;
  logic [31:0]    fchild_q, fchild_d;
  logic [7:0]     findex_q, findex_d;
  skcp_out_t      out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [IW-1:0]  raddr, waddr;
  logic           key_we, child_we;
  logic [63:0]    key_wdata, key_rdata;
  logic [31:0]    child_wdata, child_rdata;
  skcp_cmp_t      cmp;
  logic [CW:0]    mid_sum;
  logic           is_ins;

  skcp_ram #(.Width(64), .Depth(MAX_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  skcp_ram #(.Width(32), .Depth(MAX_ENTRIES)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (waddr),
    .wdata_i (child_wdata),
    .raddr_i (raddr),
    .rdata_o (child_rdata)
  );

  skcp_cmp u_cmp (
    .mem_key_i     (key_rdata),
    .probe_key_i   (req_q.key),
    .mem_child_i   (child_rdata),
    .probe_child_i (req_q.child),
    .res_o         (cmp)
  );

  assign mid_sum     = (CW + 1)'(lo_q) + (CW + 1)'(hi_q);
  assign is_ins      = req_q.operation == OP_INSERT;
  assign in_i.ready  = state_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // hold state, request and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    mid_q    <= mid_d;
    status_q <= status_d;
    fchild_q <= fchild_d;
    findex_q <= findex_d;
    out_q    <= out_d;
  end

  // sequence search, shift, scan, root write and result load
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    mid_d       = mid_q;
    found_d     = found_q;
    status_d    = status_q;
    fchild_d    = fchild_q;
    findex_d    = findex_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    raddr       = IW'(mid_q);
    waddr       = IW'(idx_q);
    key_we      = 1'b0;
    child_we    = 1'b0;
    key_wdata   = key_rdata;
    child_wdata = child_rdata;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          req_d    = in_i.data;
          status_d = ST_NOTFOUND;
          fchild_d = '0;
          findex_d = '0;
          found_d  = 1'b0;
          lo_d     = CW'(1);
          // empty node: keep the search range empty
          hi_d     = (count_q != '0) ? count_q - CW'(1) : '0;
          pos_d    = count_q;
          idx_d    = '0;
          state_d  = S_DONE;
          case (in_i.data.operation)
            OP_LOOKUP, OP_REMOVE: begin
              if (count_q != '0) state_d = S_SRCH;
            end
            OP_INSERT: begin
              if ((CW + 1)'(count_q) >= (CW + 1)'(MAX_ENTRIES)) begin
                status_d = ST_FULL;
              end else begin
                state_d = S_SRCH;
              end
            end
            OP_NEWROOT: state_d = S_ROOT1;
            OP_FIND: begin
              if (count_q != '0) state_d = S_SCAN;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (lo_q <= hi_q && !found_q) begin
          mid_d   = CW'(mid_sum >> 1);
          raddr   = IW'(mid_d);
          state_d = S_SRCH_CMP;
        end else begin
          case (req_q.operation)
            OP_LOOKUP: begin
              raddr   = IW'(pos_q - CW'(1));
              state_d = S_LK_RD;
            end
            OP_INSERT: begin
              idx_d   = count_q;
              state_d = S_SHIFT;
            end
            default: begin
              if (found_q) begin
                idx_d   = pos_q;
                state_d = S_SHIFT;
              end else begin
                state_d = S_DONE;
              end
            end
          endcase
        end
      end
      S_SRCH_CMP: begin
        state_d = S_SRCH;
        if (cmp.eq && req_q.operation == OP_INSERT) begin
          status_d = ST_EXISTS;
          state_d  = S_DONE;
        end else if (cmp.eq && req_q.operation == OP_REMOVE) begin
          found_d = 1'b1;
          pos_d   = mid_q;
        end else if (cmp.gt) begin
          if (req_q.operation == OP_LOOKUP || req_q.operation == OP_INSERT) begin
            pos_d = mid_q;
          end
          hi_d = mid_q - CW'(1);
        end else begin
          lo_d = mid_q + CW'(1);
        end
      end
      S_LK_RD: begin
        status_d = ST_OK;
        fchild_d = child_rdata;
        state_d  = S_DONE;
      end
      S_SHIFT: begin
        if (is_ins) begin
          if (idx_q > pos_q) begin
            raddr   = IW'(idx_q - CW'(1));
            state_d = S_SHIFT_WR;
          end else begin
            waddr       = IW'(pos_q);
            key_we      = 1'b1;
            child_we    = 1'b1;
            key_wdata   = req_q.key;
            child_wdata = req_q.child;
            count_d     = count_q + CW'(1);
            status_d    = ST_OK;
            state_d     = S_DONE;
          end
        end else begin
          if ((CW + 1)'(idx_q) + (CW + 1)'(1) < (CW + 1)'(count_q)) begin
            raddr   = IW'(idx_q + CW'(1));
            state_d = S_SHIFT_WR;
          end else begin
            count_d  = count_q - CW'(1);
            status_d = ST_OK;
            state_d  = S_DONE;
          end
        end
      end
      S_SHIFT_WR: begin
        key_we   = 1'b1;
        child_we = 1'b1;
        idx_d    = is_ins ? idx_q - CW'(1) : idx_q + CW'(1);
        state_d  = S_SHIFT;
      end
      S_SCAN: begin
        if (idx_q < count_q) begin
          raddr   = IW'(idx_q);
          state_d = S_SCAN_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_CMP: begin
        if (cmp.child_eq) begin
          status_d = ST_OK;
          findex_d = 8'(idx_q);
          state_d  = S_DONE;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_SCAN;
        end
      end
      S_ROOT1: begin
        waddr       = '0;
        child_we    = 1'b1;
        child_wdata = req_q.left_id;
        state_d     = S_ROOT2;
      end
      S_ROOT2: begin
        waddr       = IW'(1);
        key_we      = 1'b1;
        child_we    = 1'b1;
        key_wdata   = req_q.key;
        child_wdata = req_q.child;
        count_d     = CW'(2);
        status_d    = ST_OK;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.status      = status_q;
          out_d.found_child = fchild_q;
          out_d.found_index = findex_q;
          out_d.entry_count = 9'(count_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `SKCP_ASSERT(a_count_max, clk_i, rst_ni, (CW + 1)'(count_q) <= (CW + 1)'(MAX_ENTRIES))
  `SKCP_ASSERT(a_accept_busy, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> state_q != S_IDLE)
  `SKCP_ASSERT(a_write_busy, clk_i, rst_ni, (key_we || child_we) |-> state_q != S_IDLE)
  `SKCP_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> state_q == S_IDLE || rst_ni)
endmodule
